@@ rtl/rsq_pkg.sv @@
// Shared types and constants for the reflectance sort queue.
package rsq_pkg;

  localparam int REFL_W      = 10;
  localparam int CLASS_W     = 3;
  localparam int COUNT_OUT_W = 4;
  localparam int TALLY_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  typedef logic [CLASS_W-1:0]    class_t;
  typedef logic [REFL_W-1:0]     refl_t;
  typedef logic [TALLY_W-1:0]    tally_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Part classes
  localparam class_t CLASS_BLACK    = 3'd0;
  localparam class_t CLASS_WHITE    = 3'd1;
  localparam class_t CLASS_STEEL    = 3'd2;
  localparam class_t CLASS_ALUMINUM = 3'd3;
  localparam class_t CLASS_UNKNOWN  = 3'd4;

  // Configuration register indexes
  localparam cfg_idx_t REG_BLACK_THR        = 3'd0;
  localparam cfg_idx_t REG_WHITE_THR        = 3'd1;
  localparam cfg_idx_t REG_STEEL_THR        = 3'd2;
  localparam cfg_idx_t REG_ALUMINUM_THR     = 3'd3;
  localparam cfg_idx_t REG_UNKNOWN_TO_BLACK = 3'd4;

  // Reset values of the configuration registers
  localparam refl_t BLACK_THR_RST    = 10'd940;
  localparam refl_t WHITE_THR_RST    = 10'd880;
  localparam refl_t STEEL_THR_RST    = 10'd300;
  localparam refl_t ALUMINUM_THR_RST = 10'd15;

  // Input item kinds
  localparam logic KIND_CLASSIFY = 1'b0;
  localparam logic KIND_EXIT     = 1'b1;

  typedef struct packed {
    refl_t black_thr;
    refl_t white_thr;
    refl_t steel_thr;
    refl_t aluminum_thr;
    logic  unknown_to_black;
  } cfg_t;

  typedef struct packed {
    logic  kind;
    refl_t min_reflect;
    logic  stepper_ready;
  } in_word_t;

  // One step handed from the top level to the queue
  typedef struct packed {
    logic   go;
    logic   kind;
    logic   stepper_ready;
    class_t cls;
  } q_step_t;

  typedef struct packed {
    class_t                 item_class;
    logic                   overflow;
    logic [COUNT_OUT_W-1:0] queue_count;
    logic                   head_changed;
    logic                   bin_move;
    logic                   brake_hold;
    tally_t                 black_total;
    tally_t                 white_total;
    tally_t                 steel_total;
    tally_t                 aluminum_total;
  } result_t;

endpackage

@@ rtl/rsq_channels.sv @@
// Handshake channel interfaces: input word, result word and config write.
interface rsq_in_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  rsq_pkg::refl_t       min_reflect;
  logic                 stepper_ready;

  modport source (output valid, kind, min_reflect, stepper_ready, input ready);
  modport sink   (input valid, kind, min_reflect, stepper_ready, output ready);
endinterface

interface rsq_out_if;
  logic                                valid;
  logic                                ready;
  rsq_pkg::class_t                     item_class;
  logic                                overflow;
  logic [rsq_pkg::COUNT_OUT_W-1:0]     queue_count;
  logic                                head_changed;
  logic                                bin_move;
  logic                                brake_hold;
  rsq_pkg::tally_t                     black_total;
  rsq_pkg::tally_t                     white_total;
  rsq_pkg::tally_t                     steel_total;
  rsq_pkg::tally_t                     aluminum_total;

  modport source (output valid, item_class, overflow, queue_count, head_changed, bin_move,
                  brake_hold, black_total, white_total, steel_total, aluminum_total,
                  input ready);
  modport sink   (input valid, item_class, overflow, queue_count, head_changed, bin_move,
                  brake_hold, black_total, white_total, steel_total, aluminum_total,
                  output ready);
endinterface

interface rsq_cfg_if;
  logic                valid;
  logic                ready;
  rsq_pkg::cfg_idx_t   index;
  rsq_pkg::cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/rsq_classify.sv @@
// Threshold classifier: maps a reflectance value to a part class.
module rsq_classify (
  input  rsq_pkg::cfg_t   cfg,
  input  rsq_pkg::refl_t  min_reflect,
  output rsq_pkg::class_t cls
);

  // Descending thresholds, first strict match wins
  always_comb begin
    if (min_reflect > cfg.black_thr) begin
      cls = rsq_pkg::CLASS_BLACK;
    end else if (min_reflect > cfg.white_thr) begin
      cls = rsq_pkg::CLASS_WHITE;
    end else if (min_reflect > cfg.steel_thr) begin
      cls = rsq_pkg::CLASS_STEEL;
    end else if (min_reflect > cfg.aluminum_thr) begin
      cls = rsq_pkg::CLASS_ALUMINUM;
    end else if (cfg.unknown_to_black) begin
      cls = rsq_pkg::CLASS_BLACK;
    end else begin
      cls = rsq_pkg::CLASS_UNKNOWN;
    end
  end

endmodule

@@ rtl/rsq_queue.sv @@
// Class queue (shifting FIFO, head at slot 0) with per-class sort tallies.
module rsq_queue #(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rsq_pkg::q_step_t  step,
  output rsq_pkg::result_t  res
);

  localparam int CW = $clog2(DEPTH + 1);

  rsq_pkg::class_t ring_r   [DEPTH];
  rsq_pkg::class_t ring_nxt [DEPTH];
  logic [CW-1:0]   count_r, count_nxt;
  rsq_pkg::tally_t tally_r   [4];
  rsq_pkg::tally_t tally_nxt [4];

  logic              full, empty, enq, deq, multi;
  logic [CW+3:0]     count_wide;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign multi = (count_r > CW'(1));
  assign enq   = step.go && (step.kind == rsq_pkg::KIND_CLASSIFY) && !full;
  assign deq   = step.go && (step.kind == rsq_pkg::KIND_EXIT) && step.stepper_ready && !empty;

  // Next queue contents: shift down on dequeue, write at fill level on enqueue
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ring_nxt[i] = ring_r[i];
    end
    if (deq) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        ring_nxt[i] = ring_r[i + 1];
      end
    end else if (enq) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (count_r == CW'(i)) begin
          ring_nxt[i] = step.cls;
        end
      end
    end
  end

  // Fill level
  always_comb begin
    count_nxt = count_r;
    if (enq) begin
      count_nxt = count_r + CW'(1);
    end else if (deq) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Tally the departing head; unknown parts are not counted
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tally_nxt[i] = tally_r[i];
    end
    if (deq) begin
      case (ring_r[0])
        rsq_pkg::CLASS_BLACK:    tally_nxt[0] = tally_r[0] + 8'd1;
        rsq_pkg::CLASS_WHITE:    tally_nxt[1] = tally_r[1] + 8'd1;
        rsq_pkg::CLASS_STEEL:    tally_nxt[2] = tally_r[2] + 8'd1;
        rsq_pkg::CLASS_ALUMINUM: tally_nxt[3] = tally_r[3] + 8'd1;
        default: ;
      endcase
    end
  end

  // Result word for this step
  assign count_wide = {4'd0, count_nxt};

  always_comb begin
    res                = '0;
    res.queue_count    = count_wide[3:0];
    res.black_total    = tally_nxt[0];
    res.white_total    = tally_nxt[1];
    res.steel_total    = tally_nxt[2];
    res.aluminum_total = tally_nxt[3];
    if (step.kind == rsq_pkg::KIND_CLASSIFY) begin
      res.item_class   = step.cls;
      res.overflow     = full;
      res.head_changed = empty;
    end else if (!step.stepper_ready) begin
      res.brake_hold   = 1'b1;
    end else if (!empty) begin
      res.item_class   = ring_r[0];
      res.head_changed = multi;
      res.bin_move     = multi && (ring_r[1] != ring_r[0]);
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      ring_r[i] <= ring_nxt[i];
    end
  end

  // Control state and tallies
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < 4; i++) begin
        tally_r[i] <= '0;
      end
    end else if (step.go) begin
      count_r <= count_nxt;
      for (int i = 0; i < 4; i++) begin
        tally_r[i] <= tally_nxt[i];
      end
    end
  end

endmodule

@@ rtl/reflectance_sort_queue.sv @@
// Reflectance sort queue top level: config registers, input and result registers.
// Takes one word per cycle (classify or exit) while its input register can advance, and returns
// one result word per input word: the word lands in an input register, then the classifier and
// the queue update (a step on a shifting QUEUE_DEPTH-entry class queue and four 8-bit tallies)
// load the result register once the output is not stalled. The input side keeps accepting while
// a result waits, until both registers are full.
// Config writes are always accepted and must only be issued while the block is idle;
// writes to indexes beyond the unknown-to-black flag are ignored. queue_count reports the
// low four bits of the fill level.
module reflectance_sort_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  rsq_in_if.sink    in_ch,
  rsq_out_if.source out_ch,
  rsq_cfg_if.sink   cfg_ch
);

  rsq_pkg::cfg_t     cfg_r;
  logic              s1_valid_r;
  rsq_pkg::in_word_t s1_word_r;
  logic              out_valid_r;
  rsq_pkg::result_t  out_res_r;

  logic              advance;
  rsq_pkg::class_t   cls;
  rsq_pkg::q_step_t  step;
  rsq_pkg::result_t  step_res;

  // Config register file
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.black_thr        <= rsq_pkg::BLACK_THR_RST;
      cfg_r.white_thr        <= rsq_pkg::WHITE_THR_RST;
      cfg_r.steel_thr        <= rsq_pkg::STEEL_THR_RST;
      cfg_r.aluminum_thr     <= rsq_pkg::ALUMINUM_THR_RST;
      cfg_r.unknown_to_black <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        rsq_pkg::REG_BLACK_THR:        cfg_r.black_thr        <= cfg_ch.data;
        rsq_pkg::REG_WHITE_THR:        cfg_r.white_thr        <= cfg_ch.data;
        rsq_pkg::REG_STEEL_THR:        cfg_r.steel_thr        <= cfg_ch.data;
        rsq_pkg::REG_ALUMINUM_THR:     cfg_r.aluminum_thr     <= cfg_ch.data;
        rsq_pkg::REG_UNKNOWN_TO_BLACK: cfg_r.unknown_to_black <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_word_r.kind          <= in_ch.kind;
      s1_word_r.min_reflect   <= in_ch.min_reflect;
      s1_word_r.stepper_ready <= in_ch.stepper_ready;
    end
  end

  // Classify and step the queue
  rsq_classify u_classify (
    .cfg         (cfg_r),
    .min_reflect (s1_word_r.min_reflect),
    .cls         (cls)
  );

  assign step = '{go: advance, kind: s1_word_r.kind,
                  stepper_ready: s1_word_r.stepper_ready, cls: cls};

  rsq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.item_class     = out_res_r.item_class;
  assign out_ch.overflow       = out_res_r.overflow;
  assign out_ch.queue_count    = out_res_r.queue_count;
  assign out_ch.head_changed   = out_res_r.head_changed;
  assign out_ch.bin_move       = out_res_r.bin_move;
  assign out_ch.brake_hold     = out_res_r.brake_hold;
  assign out_ch.black_total    = out_res_r.black_total;
  assign out_ch.white_total    = out_res_r.white_total;
  assign out_ch.steel_total    = out_res_r.steel_total;
  assign out_ch.aluminum_total = out_res_r.aluminum_total;

  // A refused enqueue never touches the head or the brake
  a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.overflow) |-> (!out_res_r.head_changed && !out_res_r.brake_hold))
    else $error("overflow result also flags head change or brake");

  // A bin move only comes with a new head
  a_move_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.bin_move) |-> out_res_r.head_changed)
    else $error("bin move without head change");

  // An exit without stepper ready yields a braking result next cycle
  a_exit_brakes: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_word_r.kind == rsq_pkg::KIND_EXIT && !s1_word_r.stepper_ready)
      |=> (out_valid_r && out_res_r.brake_hold))
    else $error("exit without stepper ready did not brake");

endmodule

@@ tb/reflectance_sort_queue_test.sv @@
// Self-checking testbench for the reflectance sort queue, checked against a predictor.
module reflectance_sort_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH    = 8;
  localparam int IDLE_PCT      = 36;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 196;
  localparam int PRESSURE_ITEMS = 60;
  localparam int MAX_REPORTS   = 10;

  logic clk = 1'b0;
  logic rst_n;

  rsq_in_if  in_ch ();
  rsq_out_if out_ch ();
  rsq_cfg_if cfg_ch ();

  reflectance_sort_queue #(.QUEUE_DEPTH(RING_DEPTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Pending part events and predicted sort reports
  rsq_pkg::in_word_t part_events[$];
  rsq_pkg::result_t  sort_reports[$];
  rsq_pkg::in_word_t held_event;

  // Predictor state
  rsq_pkg::cfg_t   sorter_cfg;
  rsq_pkg::class_t ring[RING_DEPTH];
  int              ring_fill;
  int              ring_head;
  int              ring_tail;
  rsq_pkg::tally_t tallies[4];

  int   fail_count = 0;
  int   cycle_count = 0;
  logic no_gaps = 1'b0;
  logic hold_req = 1'b0;
  logic hold_off = 1'b0;

  // One sorter step: classify-and-enqueue or exit-gate dequeue
  function automatic rsq_pkg::result_t sort_part_event(rsq_pkg::in_word_t w);
    rsq_pkg::result_t r;
    rsq_pkg::class_t  cls;
    r = '0;
    if (w.kind == rsq_pkg::KIND_CLASSIFY) begin
      if (w.min_reflect > sorter_cfg.black_thr) cls = rsq_pkg::CLASS_BLACK;
      else if (w.min_reflect > sorter_cfg.white_thr) cls = rsq_pkg::CLASS_WHITE;
      else if (w.min_reflect > sorter_cfg.steel_thr) cls = rsq_pkg::CLASS_STEEL;
      else if (w.min_reflect > sorter_cfg.aluminum_thr) cls = rsq_pkg::CLASS_ALUMINUM;
      else cls = sorter_cfg.unknown_to_black ? rsq_pkg::CLASS_BLACK : rsq_pkg::CLASS_UNKNOWN;
      r.item_class = cls;
      if (ring_fill >= RING_DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        if (ring_fill == 0) r.head_changed = 1'b1;
        ring[ring_tail] = cls;
        ring_tail = (ring_tail + 1) % RING_DEPTH;
        ring_fill++;
      end
    end else if (!w.stepper_ready) begin
      r.brake_hold = 1'b1;
    end else if (ring_fill > 0) begin
      cls = ring[ring_head];
      r.item_class = cls;
      // unknown parts leave the queue without a tally
      if (cls != rsq_pkg::CLASS_UNKNOWN) tallies[cls[1:0]] = tallies[cls[1:0]] + 1'b1;
      ring_head = (ring_head + 1) % RING_DEPTH;
      ring_fill--;
      if (ring_fill > 0) begin
        r.head_changed = 1'b1;
        r.bin_move = (ring[ring_head] != cls);
      end
    end
    r.queue_count    = ring_fill[rsq_pkg::COUNT_OUT_W-1:0];
    r.black_total    = tallies[0];
    r.white_total    = tallies[1];
    r.steel_total    = tallies[2];
    r.aluminum_total = tallies[3];
    return r;
  endfunction

  function automatic rsq_pkg::in_word_t make_event(logic kind, rsq_pkg::refl_t refl,
                                                   logic ready);
    rsq_pkg::in_word_t w;
    w.kind          = kind;
    w.min_reflect   = refl;
    w.stepper_ready = ready;
    return w;
  endfunction

  // Random part event, biased toward classify by fill_pct
  function automatic rsq_pkg::in_word_t random_event(int fill_pct);
    rsq_pkg::in_word_t w;
    int                t;
    w.kind          = ($urandom_range(99) < fill_pct) ? rsq_pkg::KIND_CLASSIFY
                                                      : rsq_pkg::KIND_EXIT;
    w.stepper_ready = ($urandom_range(99) < 85);
    case ($urandom_range(3))
      0: begin
        // straddle one of the current thresholds
        case ($urandom_range(3))
          0: t = sorter_cfg.black_thr;
          1: t = sorter_cfg.white_thr;
          2: t = sorter_cfg.steel_thr;
          default: t = sorter_cfg.aluminum_thr;
        endcase
        t = t + int'($urandom_range(2)) - 1;
        if (t < 0) t = 0;
        if (t > 1023) t = 1023;
        w.min_reflect = rsq_pkg::refl_t'(t);
      end
      1: w.min_reflect = $urandom_range(1) ? '1 : '0;
      default: w.min_reflect = rsq_pkg::refl_t'($urandom_range(1023));
    endcase
    return w;
  endfunction

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.kind          <= rsq_pkg::KIND_CLASSIFY;
      in_ch.min_reflect   <= '0;
      in_ch.stepper_ready <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) sort_reports.push_back(sort_part_event(held_event));
      if (!in_ch.valid || in_ch.ready) begin
        if (part_events.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          held_event = part_events.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.kind          <= held_event.kind;
          in_ch.min_reflect   <= held_event.min_reflect;
          in_ch.stepper_ready <= held_event.stepper_ready;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    rsq_pkg::result_t seen;
    rsq_pkg::result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen = '{item_class: out_ch.item_class, overflow: out_ch.overflow,
                 queue_count: out_ch.queue_count, head_changed: out_ch.head_changed,
                 bin_move: out_ch.bin_move, brake_hold: out_ch.brake_hold,
                 black_total: out_ch.black_total, white_total: out_ch.white_total,
                 steel_total: out_ch.steel_total, aluminum_total: out_ch.aluminum_total};
        if (sort_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("ERROR %0t: result word with nothing expected, class=%0d count=%0d",
                     $realtime, seen.item_class, seen.queue_count);
        end else begin
          want = sort_reports.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display({"ERROR %0t: exp cls=%0d ovf=%0d cnt=%0d chg=%0d mv=%0d brk=%0d",
                        " tot=%0d/%0d/%0d/%0d"},
                       $realtime, want.item_class, want.overflow, want.queue_count,
                       want.head_changed, want.bin_move, want.brake_hold, want.black_total,
                       want.white_total, want.steel_total, want.aluminum_total);
              $display({"          got cls=%0d ovf=%0d cnt=%0d chg=%0d mv=%0d brk=%0d",
                        " tot=%0d/%0d/%0d/%0d"},
                       seen.item_class, seen.overflow, seen.queue_count, seen.head_changed,
                       seen.bin_move, seen.brake_hold, seen.black_total, seen.white_total,
                       seen.steel_total, seen.aluminum_total);
            end
          end
        end
      end
      out_ch.ready <= !hold_off && (no_gaps || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic cfg_write(rsq_pkg::cfg_idx_t idx, rsq_pkg::cfg_data_t val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      rsq_pkg::REG_BLACK_THR:        sorter_cfg.black_thr        = val;
      rsq_pkg::REG_WHITE_THR:        sorter_cfg.white_thr        = val;
      rsq_pkg::REG_STEEL_THR:        sorter_cfg.steel_thr        = val;
      rsq_pkg::REG_ALUMINUM_THR:     sorter_cfg.aluminum_thr     = val;
      rsq_pkg::REG_UNKNOWN_TO_BLACK: sorter_cfg.unknown_to_black = val[0];
      default: ;
    endcase
  endtask

  task automatic load_sorter_setup(rsq_pkg::cfg_t s);
    cfg_write(rsq_pkg::REG_BLACK_THR, s.black_thr);
    cfg_write(rsq_pkg::REG_WHITE_THR, s.white_thr);
    cfg_write(rsq_pkg::REG_STEEL_THR, s.steel_thr);
    cfg_write(rsq_pkg::REG_ALUMINUM_THR, s.aluminum_thr);
    cfg_write(rsq_pkg::REG_UNKNOWN_TO_BLACK, rsq_pkg::cfg_data_t'(s.unknown_to_black));
    @(negedge clk);
  endtask

  // Wait until every word is accepted and every report has arrived
  task automatic wait_idle();
    do @(negedge clk);
    while (part_events.size() != 0 || in_ch.valid || sort_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Main sequence
  initial begin
    rsq_pkg::cfg_t plan;
    int            a;
    int            b;
    int            c;
    int            d;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = rsq_pkg::REG_BLACK_THR;
    cfg_ch.data         = '0;
    sorter_cfg = '{black_thr: rsq_pkg::BLACK_THR_RST, white_thr: rsq_pkg::WHITE_THR_RST,
                   steel_thr: rsq_pkg::STEEL_THR_RST,
                   aluminum_thr: rsq_pkg::ALUMINUM_THR_RST, unknown_to_black: 1'b0};
    ring_fill = 0;
    ring_head = 0;
    ring_tail = 0;
    foreach (tallies[i]) tallies[i] = '0;
    foreach (ring[i]) ring[i] = rsq_pkg::CLASS_BLACK;

    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-queue exits, threshold edges, overflow, full drain, unknown at exit
    part_events.push_back(make_event(rsq_pkg::KIND_EXIT, '0, 1'b1));
    part_events.push_back(make_event(rsq_pkg::KIND_EXIT, '1, 1'b0));
    part_events.push_back(make_event(rsq_pkg::KIND_CLASSIFY, '1, 1'b0));
    part_events.push_back(make_event(rsq_pkg::KIND_CLASSIFY,
                                     rsq_pkg::BLACK_THR_RST + 1'b1, 1'b1));
    part_events.push_back(make_event(rsq_pkg::KIND_CLASSIFY, rsq_pkg::BLACK_THR_RST, 1'b0));
    part_events.push_back(make_event(rsq_pkg::KIND_CLASSIFY,
                                     rsq_pkg::WHITE_THR_RST + 1'b1, 1'b1));
    part_events.push_back(make_event(rsq_pkg::KIND_CLASSIFY, rsq_pkg::WHITE_THR_RST, 1'b0));
    part_events.push_back(make_event(rsq_pkg::KIND_CLASSIFY,
                                     rsq_pkg::STEEL_THR_RST + 1'b1, 1'b1));
    part_events.push_back(make_event(rsq_pkg::KIND_CLASSIFY, rsq_pkg::STEEL_THR_RST, 1'b0));
    part_events.push_back(make_event(rsq_pkg::KIND_CLASSIFY,
                                     rsq_pkg::ALUMINUM_THR_RST + 1'b1, 1'b1));
    part_events.push_back(make_event(rsq_pkg::KIND_CLASSIFY, '0, 1'b1));
    part_events.push_back(make_event(rsq_pkg::KIND_CLASSIFY,
                                     rsq_pkg::ALUMINUM_THR_RST, 1'b0));
    part_events.push_back(make_event(rsq_pkg::KIND_EXIT, '0, 1'b0));
    repeat (RING_DEPTH) part_events.push_back(make_event(rsq_pkg::KIND_EXIT, '1, 1'b1));
    part_events.push_back(make_event(rsq_pkg::KIND_CLASSIFY,
                                     rsq_pkg::ALUMINUM_THR_RST, 1'b1));
    part_events.push_back(make_event(rsq_pkg::KIND_EXIT, '0, 1'b1));
    part_events.push_back(make_event(rsq_pkg::KIND_EXIT, '0, 1'b1));
    wait_idle();

    // Random phases, each under its own threshold setup
    for (int ph = 0; ph < 8; ph++) begin
      a = $urandom_range(1023);
      b = $urandom_range(a);
      c = $urandom_range(b);
      d = $urandom_range(c);
      case (ph)
        0: plan = '{rsq_pkg::BLACK_THR_RST, rsq_pkg::WHITE_THR_RST, rsq_pkg::STEEL_THR_RST,
                    rsq_pkg::ALUMINUM_THR_RST, 1'b0};
        1: plan = '{'0, '0, '0, '0, 1'b1};
        2: plan = '{'1, '1, '1, '1, 1'b0};
        3: plan = '{'1, rsq_pkg::refl_t'(1022), rsq_pkg::refl_t'(1), '0, 1'b1};
        4: plan = '{rsq_pkg::refl_t'(a), rsq_pkg::refl_t'(b), rsq_pkg::refl_t'(c),
                    rsq_pkg::refl_t'(d), 1'($urandom_range(1))};
        5: plan = '{rsq_pkg::refl_t'($urandom_range(1023)),
                    rsq_pkg::refl_t'($urandom_range(1023)),
                    rsq_pkg::refl_t'($urandom_range(1023)),
                    rsq_pkg::refl_t'($urandom_range(1023)),
                    1'($urandom_range(1))};
        6: plan = '{rsq_pkg::refl_t'(a), rsq_pkg::refl_t'(b), rsq_pkg::refl_t'(c),
                    rsq_pkg::refl_t'(d), 1'b0};
        default: plan = '{rsq_pkg::BLACK_THR_RST, rsq_pkg::WHITE_THR_RST,
                          rsq_pkg::STEEL_THR_RST, rsq_pkg::ALUMINUM_THR_RST, 1'b1};
      endcase
      load_sorter_setup(plan);
      // one phase runs back to back with no idling on either side
      no_gaps = (ph == 4);
      for (int n = 0; n < PHASE_ITEMS; n++)
        part_events.push_back(random_event((ph % 3 == 0) ? 35 : ((ph % 3 == 1) ? 50 : 65)));
      wait_idle();
    end

    // Backpressure: receiver holds off while the sender keeps offering words
    no_gaps = 1'b1;
    hold_req = 1'b1;
    for (int n = 0; n < PRESSURE_ITEMS; n++) part_events.push_back(random_event(60));
    wait_idle();
    no_gaps = 1'b0;

    if (sort_reports.size() != 0) begin
      fail_count++;
      $display("ERROR: %0d expected result words never arrived", sort_reports.size());
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
